FILE: src/brb_pkg.sv
// Shared types, constants and helpers for the byte ring buffer.
package brb_pkg;

   typedef logic [7:0] byte_type;

   localparam int LANES     = 8;
   localparam int LANE_BITS = 3;

   localparam logic [3:0] MAX_BYTES = 4'd8;

   localparam logic OP_PUT = 1'b0;
   localparam logic OP_GET = 1'b1;

   function automatic logic [3:0] sat_count(input logic [3:0] count);
      logic [3:0] result;
      result = (count > MAX_BYTES) ? MAX_BYTES : count;
      return result;
   endfunction

endpackage

FILE: src/byte_ring_buffer.sv
// Top level of the byte ring buffer: index control, lane banks and result register.
// A put of up to eight bytes loads the result register directly. A get first reads the
// eight byte-lane RAMs that hold the ring (byte address a lives in lane a mod 8, so any
// eight consecutive bytes are read or written in a single access), whose read port is
// registered, and then loads the result register. Puts are all-or-nothing and keep the
// fill below DEPTH. A new beat is taken once the block is idle and the result register
// is empty or being drained in the same cycle. The store needs no clearing after reset.
module byte_ring_buffer #(
   parameter int DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // byte_count[3:0], put_data[67:4], zero pad
   input  logic [0:0]  req_tuser,  // operation[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata   // done_count[3:0], get_data[67:4], fill_level[79:68]
);

   localparam int AW = $clog2(DEPTH);
   localparam int RW = AW - brb_pkg::LANE_BITS;
   localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_GET  = 1'b1;

   logic          state_ff, state_in;
   logic [AW-1:0] wr_ff, wr_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [79:0]   rsp_data_ff, rsp_data_in;
   logic [2:0]    get_lo_ff, get_lo_in;
   logic [3:0]    get_n_ff, get_n_in;
   logic [11:0]   get_fill_ff, get_fill_in;

   logic          out_free;
   logic          req_fire;
   logic          is_get;
   logic [3:0]    cnt;
   logic [63:0]   put_data;
   logic [AW-1:0] used;
   logic          fits;
   logic [3:0]    n;
   logic [AW-1:0] fill_put;
   logic [AW-1:0] fill_get;
   logic [127:0]  wr_rot;
   logic [127:0]  rd_rot;
   logic [63:0]   lanes_q;
   logic [63:0]   get_data;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign is_get     = (req_tuser[0] == brb_pkg::OP_GET);
   assign cnt        = brb_pkg::sat_count(req_tdata[3:0]);
   assign put_data   = req_tdata[67:4];
   assign used       = wr_ff - rd_ff;
   assign fits       = (({1'b0, used} + (AW+1)'(cnt)) < DEPTH_W);
   assign n          = ({1'b0, used} >= (AW+1)'(cnt)) ? cnt : used[3:0];
   assign fill_put   = used + AW'(cnt);
   assign fill_get   = used - AW'(n);
   assign wr_rot     = {put_data, put_data} << {wr_ff[2:0], 3'b000};

   for (genvar b = 0; b < brb_pkg::LANES; b++) begin : g_lane
      logic [2:0]    wr_off;
      logic          lane_we;
      logic [RW-1:0] lane_wr_row;
      logic [RW-1:0] lane_rd_row;

      assign wr_off      = 3'(b) - wr_ff[2:0];
      assign lane_we     = req_fire && !is_get && fits && ({1'b0, wr_off} < cnt);
      assign lane_wr_row = wr_ff[AW-1:3] + RW'(3'(b) < wr_ff[2:0]);
      assign lane_rd_row = rd_ff[AW-1:3] + RW'(3'(b) < rd_ff[2:0]);

      brb_bank #(.RW(RW)) u_bank (
         .clock   (clock),
         .wr_en   (lane_we),
         .wr_row  (lane_wr_row),
         .wr_byte (wr_rot[64 + 8*b +: 8]),
         .rd_en   (req_fire && is_get),
         .rd_row  (lane_rd_row),
         .rd_byte (lanes_q[8*b +: 8])
      );
   end

   assign rd_rot = {lanes_q, lanes_q} >> {get_lo_ff, 3'b000};

   always_comb begin
      for (int i = 0; i < brb_pkg::LANES; i++) begin
         get_data[8*i +: 8] = (4'(i) < get_n_ff) ? rd_rot[8*i +: 8] : 8'h00;
      end
   end

   always_comb begin
      state_in     = state_ff;
      wr_in        = wr_ff;
      rd_in        = rd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      get_lo_in    = get_lo_ff;
      get_n_in     = get_n_ff;
      get_fill_in  = get_fill_ff;
      priority if (req_fire && is_get) begin
         rd_in       = rd_ff + AW'(n);
         get_lo_in   = rd_ff[2:0];
         get_n_in    = n;
         get_fill_in = 12'(fill_get);
         state_in    = S_GET;
      end else if (req_fire) begin
         rsp_valid_in = 1'b1;
         if (fits) begin
            wr_in       = fill_put + rd_ff;
            rsp_data_in = {12'(fill_put), 64'd0, cnt};
         end else begin
            rsp_data_in = {12'(used), 64'd0, 4'd0};
         end
      end else if (state_ff == S_GET) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {get_fill_ff, get_data, get_n_ff};
         state_in     = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_ff        <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      get_lo_ff   <= get_lo_in;
      get_n_ff    <= get_n_in;
      get_fill_ff <= get_fill_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_get_reads: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_get |=> state_ff == S_GET)
      else $error("get beat did not enter read cycle");

   a_get_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GET |-> !rsp_valid_ff)
      else $error("result register busy when get data returns");

   a_drop_hold: assert property (@(posedge clock) disable iff (reset)
      req_fire && !is_get && !fits |=> $stable(wr_ff))
      else $error("dropped put moved write index");

   a_done_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3:0] <= brb_pkg::MAX_BYTES)
      else $error("done count above limit");

endmodule

FILE: src/brb_bank.sv
// One byte lane of the ring store: synchronous RAM, one write and one registered read port.
module brb_bank #(
   parameter int RW = 9
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [RW-1:0]      wr_row,
   input  brb_pkg::byte_type  wr_byte,
   input  logic               rd_en,
   input  logic [RW-1:0]      rd_row,
   output brb_pkg::byte_type  rd_byte
);

   brb_pkg::byte_type mem [2**RW];
   brb_pkg::byte_type rd_byte_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_byte_ff <= mem[rd_row];
      end
   end

   assign rd_byte = rd_byte_ff;

endmodule
